FILE: design/lhm_pkg.sv
// shared types and constants for the linear probing hash map
// no dependencies; imported by lhm_ctrl, lhm_datapath and the top level
`default_nettype none

package lhm_pkg;

	localparam int CNT_W        = 7;
	localparam int OP_W         = 2;
	localparam int FIELD_W      = 32;
	localparam int HASH_DIGIT_W = 4;
	localparam int HASH_DIGITS  = FIELD_W / HASH_DIGIT_W;
	localparam int DIG_W        = $clog2(HASH_DIGITS);

	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd48;

	// slot flags: bit 0 live, bit 1 tombstone
	localparam logic [1:0] FLAGS_EMPTY = 2'b00;
	localparam logic [1:0] FLAGS_LIVE  = 2'b01;
	localparam logic [1:0] FLAGS_TOMB  = 2'b10;
	localparam int FLAG_LIVE_BIT = 0;
	localparam int FLAG_TOMB_BIT = 1;

	typedef enum logic [OP_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic probe_start;
		logic probe_run;
		logic commit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mod_busy;
		logic probe_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: design/lhm_ctrl.sv
// controller state machine of the hash map: clear sweep, hash reduce, probe, commit
// depends on lhm_pkg for state_t, cmd_t and sts_t
`default_nettype none

module lhm_ctrl import lhm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (!sts.mod_busy) state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.probe_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_HASH: begin
				cmd.mod_step    = 1'b1;
				cmd.probe_start = !sts.mod_busy;
			end
			ST_PROBE:  cmd.probe_run = 1'b1;
			ST_COMMIT: cmd.commit    = sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/lhm_datapath.sv
// datapath of the hash map: slot memories, hash reduce unit, probe tracking,
// live count, load limit register and output register; depends on lhm_pkg
`default_nettype none

module lhm_datapath import lhm_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic               cfg_wr_en,
	input  wire logic [CNT_W-1:0]   cfg_wr_data,
	input  wire logic [OP_W-1:0]    req_type,
	input  wire logic [FIELD_W-1:0] key,
	input  wire logic [FIELD_W-1:0] key_hash,
	input  wire logic [FIELD_W-1:0] write_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [FIELD_W-1:0]      read_value,
	output logic                    rejected,
	output logic [CNT_W-1:0]        live_count
);

	localparam int IW = $clog2(SLOTS);
	localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
	localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

	// slot stores
	logic [KW-1:0] key_mem  [SLOTS];
	logic [VW-1:0] val_mem  [SLOTS];
	logic [1:0]    flag_mem [SLOTS];

	// request word
	logic [OP_W-1:0] op_q;
	logic [KW-1:0]   key_q;
	logic [VW-1:0]   val_q;

	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] cnt_q;

	logic [IW-1:0] rem_q;
	logic          mod_busy;

	// probe
	logic [IW-1:0] idx_q, idx_inc, idx_s1;
	logic          rvalid_s1;
	logic [KW-1:0] rkey_s1;
	logic [VW-1:0] rval_s1;
	logic [1:0]    rflag_s1;
	logic [IW-1:0] ecnt_q;
	logic          done_q, found_q, free_q, tseen_q;
	logic [IW-1:0] where_q, tidx_q;
	logic [VW-1:0] fval_q;

	logic          eval_en, hit_now, empty_now, tomb_now, last_now, tseen_n;
	logic [IW-1:0] tidx_n;

	// commit
	logic             lim_full, do_ins, do_upd, do_rem, op_valid, rej_d;
	logic [CNT_W-1:0] cnt_d;
	logic [VW-1:0]    rd_d;
	logic             flag_we;
	logic [IW-1:0]    flag_addr;
	logic [1:0]       flag_wdata;

	logic out_valid_q;

	assign idx_inc = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_type;
			key_q <= key[KW-1:0];
			val_q <= write_value[VW-1:0];
		end
	end

	// start slot = key_hash mod SLOTS
	generate
		if (POW2) begin : g_mod_mask
			assign mod_busy = 1'b0;
			always_ff @(posedge clk) begin
				if (cmd.load) rem_q <= key_hash[IW-1:0];
			end
		end else begin : g_mod_iter
			localparam logic [IW+HASH_DIGIT_W-1:0] SL = (IW + HASH_DIGIT_W)'(SLOTS);
			logic [FIELD_W-1:0]           hash_q;
			logic [DIG_W-1:0]             dig_q;
			logic                         busy_q;
			logic [IW+HASH_DIGIT_W-1:0]   red;

			// one hex digit per cycle, remainder stays below SLOTS
			always_comb begin
				red = {rem_q, hash_q[FIELD_W-1 -: HASH_DIGIT_W]};
				for (int k = HASH_DIGIT_W - 1; k >= 0; k--) begin
					if (red >= (SL << k)) red = red - (SL << k);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					dig_q  <= '0;
				end else if (cmd.load) begin
					busy_q <= 1'b1;
					dig_q  <= '0;
				end else if (cmd.mod_step && busy_q) begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == DIG_W'(HASH_DIGITS - 1)) busy_q <= 1'b0;
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					hash_q <= key_hash;
					rem_q  <= '0;
				end else if (cmd.mod_step && busy_q) begin
					hash_q <= hash_q << HASH_DIGIT_W;
					rem_q  <= red[IW-1:0];
				end
			end

			assign mod_busy = busy_q;
		end
	endgenerate

	// slot address: clear sweep, then probe stream one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else if (cmd.probe_start) begin
			idx_q     <= rem_q;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.probe_run && !done_q;
			if (cmd.clear || (cmd.probe_run && !done_q)) idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= idx_q;
		rkey_s1  <= key_mem[idx_q];
		rval_s1  <= val_mem[idx_q];
		rflag_s1 <= flag_mem[idx_q];
	end

	always_comb begin
		eval_en   = rvalid_s1 && !done_q;
		hit_now   = eval_en && rflag_s1[FLAG_LIVE_BIT] && (rkey_s1 == key_q);
		tomb_now  = eval_en && !rflag_s1[FLAG_LIVE_BIT] && rflag_s1[FLAG_TOMB_BIT];
		empty_now = eval_en && !rflag_s1[FLAG_LIVE_BIT] && !rflag_s1[FLAG_TOMB_BIT];
		last_now  = eval_en && (ecnt_q == LAST_SLOT);
		tseen_n   = tseen_q || tomb_now;
		tidx_n    = (tomb_now && !tseen_q) ? idx_s1 : tidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			tseen_q <= 1'b0;
			ecnt_q  <= '0;
			where_q <= '0;
			tidx_q  <= '0;
		end else if (cmd.probe_start) begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			tseen_q <= 1'b0;
			ecnt_q  <= '0;
		end else if (eval_en) begin
			tseen_q <= tseen_n;
			tidx_q  <= tidx_n;
			ecnt_q  <= ecnt_q + 1'b1;
			if (hit_now) begin
				found_q <= 1'b1;
				where_q <= idx_s1;
				done_q  <= 1'b1;
			end else if (empty_now) begin
				// reuse the first tombstone passed
				where_q <= tseen_q ? tidx_q : idx_s1;
				free_q  <= 1'b1;
				done_q  <= 1'b1;
			end else if (last_now) begin
				where_q <= tidx_n;
				free_q  <= tseen_n;
				done_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) fval_q <= rval_s1;
	end

	// commit decision
	always_comb begin
		lim_full = ({1'b0, cnt_q} + 8'd1) > {1'b0, limit_q};
		do_ins   = 1'b0;
		do_upd   = 1'b0;
		do_rem   = 1'b0;
		rej_d    = 1'b0;
		rd_d     = '0;
		op_valid = 1'b1;
		cnt_d    = cnt_q;
		case (op_q)
			REQ_ADD: begin
				if (lim_full || (!found_q && !free_q)) begin
					rej_d = 1'b1;
				end else if (found_q) begin
					do_upd = 1'b1;
				end else begin
					do_ins = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			REQ_GET: begin
				if (found_q) rd_d = fval_q;
			end
			REQ_REMOVE: begin
				if (found_q) begin
					do_rem = 1'b1;
					if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
				end
			end
			default: op_valid = 1'b0;
		endcase
	end

	assign flag_we    = cmd.clear || (cmd.commit && (do_ins || do_rem));
	assign flag_addr  = cmd.clear ? idx_q : where_q;
	assign flag_wdata = cmd.clear ? FLAGS_EMPTY : (do_ins ? FLAGS_LIVE : FLAGS_TOMB);

	always_ff @(posedge clk) begin
		if (cmd.commit && do_ins) key_mem[where_q] <= key_q;
		if (cmd.commit && (do_ins || do_upd)) val_mem[where_q] <= val_q;
		if (flag_we) flag_mem[flag_addr] <= flag_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit        <= found_q && op_valid;
			read_value <= FIELD_W'(rd_d);
			rejected   <= rej_d;
			live_count <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.clear_last = idx_q == LAST_SLOT;
	assign sts.mod_busy   = mod_busy;
	assign sts.probe_done = done_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(SLOTS))
		else $error("live count above slot count");

	a_found_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && found_q |-> !free_q)
		else $error("probe reports both a match and a free slot");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (cnt_q == $past(cnt_q)) || (cnt_q == CNT_W'($past(cnt_q) + 1'b1))
			|| (cnt_q == CNT_W'($past(cnt_q) - 1'b1)))
		else $error("live count moved by more than one");

	a_where_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> where_q <= LAST_SLOT)
		else $error("probe slot out of range");

endmodule

`default_nettype wire

FILE: design/linear_probe_hash_map.sv
// linear probing hash map, one request at a time.
// the probe visits k slots (k = 1..SLOTS) before the result is valid; when SLOTS is not
// a power of two, the start slot is first reduced one hex digit a cycle.
// a new request is taken only once the last one has been committed to the output register.
// after reset a sweep over every slot clears the slot flags before in_ready rises.
`default_nettype none

module linear_probe_hash_map import lhm_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CNT_W-1:0]   cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OP_W-1:0]    req_type,
	input  wire logic [FIELD_W-1:0] key,
	input  wire logic [FIELD_W-1:0] key_hash,
	input  wire logic [FIELD_W-1:0] write_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [FIELD_W-1:0]      read_value,
	output logic                    rejected,
	output logic [CNT_W-1:0]        live_count
);

	cmd_t cmd;
	sts_t sts;

	lhm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhm_datapath #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.key         (key),
		.key_hash    (key_hash),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.rejected    (rejected),
		.live_count  (live_count)
	);

endmodule

`default_nettype wire
